// File: rtl/core/asrl_pkg.sv
package asrl_pkg;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int RAW_W     = 12;
   localparam int LOG_W     = 13;
   localparam int AXIS_W    = 16;
   localparam int SUM_W     = 20;
   localparam int MAG_W     = 19;
   localparam int CNT_W     = 4;
   localparam int REMAP_W   = 3;
   localparam int ONE_G_W   = 13;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 3;

   // operating modes carried with every sample
   typedef enum logic [MODE_W-1:0] {
      MODE_READ      = 3'd0,
      MODE_CAL_START = 3'd1,
      MODE_CAL_SAMPLE = 3'd2,
      MODE_CAL_ABORT = 3'd3,
      MODE_LOAD      = 3'd4
   } mode_type;

   // register indexes on the control port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REMAP_X = 3'd0,
      CSR_REMAP_Y = 3'd1,
      CSR_REMAP_Z = 3'd2,
      CSR_ONE_G   = 3'd3
   } csr_index_type;

   // remap codes: positive picks a physical axis, negative picks and inverts
   localparam logic [REMAP_W-1:0] REMAP_POS_X = 3'b001;
   localparam logic [REMAP_W-1:0] REMAP_POS_Y = 3'b010;
   localparam logic [REMAP_W-1:0] REMAP_POS_Z = 3'b011;
   localparam logic [REMAP_W-1:0] REMAP_NEG_X = 3'b111;
   localparam logic [REMAP_W-1:0] REMAP_NEG_Y = 3'b110;
   localparam logic [REMAP_W-1:0] REMAP_NEG_Z = 3'b101;

   localparam logic [ONE_G_W-1:0] ONE_G_RESET = 13'd1024;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [BYTE_W-1:0]  x_low_byte;
      logic [BYTE_W-1:0]  x_high_byte;
      logic [BYTE_W-1:0]  y_low_byte;
      logic [BYTE_W-1:0]  y_high_byte;
      logic [BYTE_W-1:0]  z_low_byte;
      logic [BYTE_W-1:0]  z_high_byte;
      logic signed [AXIS_W-1:0] load_offset_x;
      logic signed [AXIS_W-1:0] load_offset_y;
      logic signed [AXIS_W-1:0] load_offset_z;
   } req_word_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic                     is_calibrated;
      logic                     calibration_done;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [ONE_G_W-1:0]   wdata;
   } csr_word_type;

   // per-word control shared by the three axis lanes
   typedef struct packed {
      logic accept;
      logic clr_off;
      logic load_off;
      logic clr_sum;
      logic accum;
      logic complete;
      logic div_abs;
      logic div_mul;
      logic div_wr;
   } lane_ctrl_type;

   // pick one logical axis out of the three physical ones
   function automatic logic signed [LOG_W-1:0] remap_pick(
      input logic [REMAP_W-1:0]      code,
      input logic signed [RAW_W-1:0] px,
      input logic signed [RAW_W-1:0] py,
      input logic signed [RAW_W-1:0] pz
   );
      logic signed [LOG_W-1:0] ex;
      logic signed [LOG_W-1:0] ey;
      logic signed [LOG_W-1:0] ez;
      logic signed [LOG_W-1:0] res;
      ex = {px[RAW_W-1], px};
      ey = {py[RAW_W-1], py};
      ez = {pz[RAW_W-1], pz};
      case (code)
         REMAP_POS_X: res = ex;
         REMAP_POS_Y: res = ey;
         REMAP_POS_Z: res = ez;
         REMAP_NEG_X: res = -ex;
         REMAP_NEG_Y: res = -ey;
         REMAP_NEG_Z: res = -ez;
         default:     res = '0;
      endcase
      return res;
   endfunction

endpackage

// File: rtl/core/asrl_chan_if.sv
interface asrl_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/asrl_lane.sv
module asrl_lane
   import asrl_pkg::*;
#(
   parameter int CAL_SAMPLE_COUNT = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  logic signed [LOG_W-1:0]  logical_val,
   input  logic signed [AXIS_W-1:0] load_val,
   input  logic [ONE_G_W-1:0]       level_bias,
   output logic signed [AXIS_W-1:0] axis_out
);

   // reciprocal of the sample count, exact floor for magnitudes below 2^MAG_W
   localparam int DIV_K = MAG_W + CNT_W;
   localparam int RECIP_W = DIV_K + 1;
   localparam int PROD_W = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << DIV_K) + CAL_SAMPLE_COUNT - 1) / CAL_SAMPLE_COUNT);

   logic [AXIS_W-1:0]  offset_ff, offset_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SUM_W-1:0]   div_sum_ff, div_sum_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic [AXIS_W-1:0]  offset_eff;
   logic [AXIS_W-1:0]  axis_val;
   logic [SUM_W-1:0]   sum_next;
   logic [SUM_W-1:0]   sum_abs;
   logic [MAG_W-1:0]   quot;
   logic [AXIS_W-1:0]  mean_val;

   // offset seen by the current word, after any clear or load it carries
   always_comb begin
      if (ctrl.clr_off) begin
         offset_eff = '0;
      end else if (ctrl.load_off) begin
         offset_eff = load_val;
      end else begin
         offset_eff = offset_ff;
      end
   end

   assign axis_val = {{(AXIS_W-LOG_W){logical_val[LOG_W-1]}}, logical_val} - offset_eff;
   assign axis_out = axis_val;
   assign sum_next = sum_ff + {{(SUM_W-AXIS_W){axis_val[AXIS_W-1]}}, axis_val};

   // accumulator
   always_comb begin
      sum_in     = sum_ff;
      div_sum_in = div_sum_ff;
      if (ctrl.accept) begin
         if (ctrl.clr_sum) begin
            sum_in = '0;
         end else if (ctrl.accum) begin
            if (ctrl.complete) begin
               sum_in     = '0;
               div_sum_in = sum_next;
            end else begin
               sum_in = sum_next;
            end
         end
      end
   end

   // mean: magnitude, reciprocal multiply, then sign and level bias
   assign sum_abs = div_sum_ff[SUM_W-1] ? (SUM_W'(0) - div_sum_ff) : div_sum_ff;
   assign mag_in  = ctrl.div_abs ? sum_abs[MAG_W-1:0] : mag_ff;
   assign neg_in  = ctrl.div_abs ? div_sum_ff[SUM_W-1] : neg_ff;
   assign prod_in = ctrl.div_mul ? (PROD_W'(mag_ff) * PROD_W'(RECIP)) : prod_ff;
   assign quot    = prod_ff[DIV_K +: MAG_W];
   assign mean_val = (neg_ff ? (AXIS_W'(0) - quot[AXIS_W-1:0]) : quot[AXIS_W-1:0])
                     + {{(AXIS_W-ONE_G_W){1'b0}}, level_bias};

   // offset store
   always_comb begin
      offset_in = offset_ff;
      if (ctrl.div_wr) begin
         offset_in = mean_val;
      end else if (ctrl.accept && (ctrl.clr_off || ctrl.load_off)) begin
         offset_in = offset_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sum_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      div_sum_ff <= div_sum_in;
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      prod_ff    <= prod_in;
   end

endmodule

// File: rtl/core/asrl_merge.sv
module asrl_merge
   import asrl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic signed [AXIS_W-1:0] lane_x,
   input  logic signed [AXIS_W-1:0] lane_y,
   input  logic signed [AXIS_W-1:0] lane_z,
   input  logic                     cal_flag,
   input  logic                     cal_done,
   output logic                     space_ok,
   asrl_chan_if.source              rsp_port
);

   rsp_word_type head_ff, head_in;
   rsp_word_type skid_ff, skid_in;
   logic [1:0]   cnt_ff, cnt_in;
   rsp_word_type word;
   logic         pop;

   // gather the three lanes and the flags into one word
   always_comb begin
      word.accel_x          = lane_x;
      word.accel_y          = lane_y;
      word.accel_z          = lane_z;
      word.is_calibrated    = cal_flag;
      word.calibration_done = cal_done;
   end

   assign pop            = rsp_port.valid && rsp_port.ready;
   assign rsp_port.valid = (cnt_ff != 2'd0);
   assign rsp_port.data  = head_ff;
   assign space_ok       = (cnt_ff != 2'd2);

   // two-word output buffer: head register plus skid
   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      cnt_in  = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = word;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = word;
            end else if (push) begin
               skid_in = word;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = skid_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// File: rtl/core/accel_sample_remap_level_cal_unit.sv
// accelerometer sample remap and level calibration
//
// req_port takes one raw sample word per handshake: mode, six sensor bytes
// (12-bit left-aligned axes, low byte first) and three offsets for loading.
// rsp_port gives one word per sample: remapped axes minus offsets, the
// calibrated flag and a pulse on the sample that finished a calibration.
// csr_port writes the remap codes and the counts per g (indexes 0 to 3).
// Each result is registered in the output buffer before rsp_port shows it.
// A word is taken every cycle, except that the calibration sample which
// completes the average blocks req_port and csr_port while the three
// lanes form the mean through a registered abs, a reciprocal multiply
// and the offset write.
// A two-word output buffer lets a new word in while a result waits; when
// the receiver stalls, req_port.ready drops once both entries are full.
// Reset (synchronous) restores the register defaults and clears offsets,
// sums, sample count and the calibrated flag.
module accel_sample_remap_level_cal_unit
   import asrl_pkg::*;
#(
   parameter int CAL_SAMPLE_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   asrl_chan_if.sink   req_port,
   asrl_chan_if.source rsp_port,
   asrl_chan_if.sink   csr_port
);

   localparam logic [CNT_W-1:0] CAL_CNT = CNT_W'(CAL_SAMPLE_COUNT);

   logic [REMAP_W-1:0] remap_x_ff, remap_x_in;
   logic [REMAP_W-1:0] remap_y_ff, remap_y_in;
   logic [REMAP_W-1:0] remap_z_ff, remap_z_in;
   logic [ONE_G_W-1:0] one_g_ff, one_g_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               cal_ff, cal_in;
   logic [2:0]         div_stage_ff, div_stage_in;

   req_word_type  req_word;
   csr_word_type  csr_word;
   lane_ctrl_type ctrl;
   logic          busy;
   logic          space_ok;
   logic          req_accept;
   logic          csr_accept;
   logic          is_start, is_sample, is_abort, is_load;
   logic [CNT_W-1:0] cnt_inc;
   logic          complete;
   logic          cal_next;

   logic signed [RAW_W-1:0]  phys_x, phys_y, phys_z;
   logic signed [LOG_W-1:0]  log_x, log_y, log_z;
   logic signed [AXIS_W-1:0] lane_x, lane_y, lane_z;

   // handshakes
   assign busy           = |div_stage_ff;
   assign req_word       = req_port.data;
   assign csr_word       = csr_port.data;
   assign req_port.ready = space_ok && !busy;
   assign csr_port.ready = !busy;
   assign req_accept     = req_port.valid && req_port.ready;
   assign csr_accept     = csr_port.valid && csr_port.ready;

   // control registers
   always_comb begin
      remap_x_in = remap_x_ff;
      remap_y_in = remap_y_ff;
      remap_z_in = remap_z_ff;
      one_g_in   = one_g_ff;
      if (csr_accept) begin
         case (csr_word.index)
            CSR_REMAP_X: remap_x_in = csr_word.wdata[REMAP_W-1:0];
            CSR_REMAP_Y: remap_y_in = csr_word.wdata[REMAP_W-1:0];
            CSR_REMAP_Z: remap_z_in = csr_word.wdata[REMAP_W-1:0];
            CSR_ONE_G:   one_g_in   = csr_word.wdata;
            default: begin
               one_g_in = one_g_ff;
            end
         endcase
      end
   end

   // unpack the raw bytes and remap onto logical axes
   assign phys_x = {req_word.x_high_byte, req_word.x_low_byte[BYTE_W-1:4]};
   assign phys_y = {req_word.y_high_byte, req_word.y_low_byte[BYTE_W-1:4]};
   assign phys_z = {req_word.z_high_byte, req_word.z_low_byte[BYTE_W-1:4]};
   assign log_x  = remap_pick(remap_x_ff, phys_x, phys_y, phys_z);
   assign log_y  = remap_pick(remap_y_ff, phys_x, phys_y, phys_z);
   assign log_z  = remap_pick(remap_z_ff, phys_x, phys_y, phys_z);

   // mode decode, unused codes act as a plain read
   always_comb begin
      is_start  = 1'b0;
      is_sample = 1'b0;
      is_abort  = 1'b0;
      is_load   = 1'b0;
      case (req_word.mode)
         MODE_CAL_START:  is_start  = 1'b1;
         MODE_CAL_SAMPLE: is_sample = 1'b1;
         MODE_CAL_ABORT:  is_abort  = 1'b1;
         MODE_LOAD:       is_load   = 1'b1;
         default: begin
            is_start = 1'b0;
         end
      endcase
   end

   // sample count and calibrated flag
   assign cnt_inc  = cnt_ff + CNT_W'(1);
   assign complete = is_sample && (cnt_inc >= CAL_CNT);
   assign cal_next = is_abort ? 1'b0 : ((is_load || complete) ? 1'b1 : cal_ff);

   always_comb begin
      cnt_in = cnt_ff;
      cal_in = cal_ff;
      if (req_accept) begin
         cal_in = cal_next;
         if (is_start || is_abort || complete) begin
            cnt_in = '0;
         end else if (is_sample) begin
            cnt_in = cnt_inc;
         end
      end
   end

   // mean pipeline runs while the input is held off
   assign div_stage_in = {div_stage_ff[1:0], req_accept && complete};

   always_comb begin
      ctrl.accept   = req_accept;
      ctrl.clr_off  = is_start;
      ctrl.load_off = is_load;
      ctrl.clr_sum  = is_start || is_abort;
      ctrl.accum    = is_sample;
      ctrl.complete = complete;
      ctrl.div_abs  = div_stage_ff[0];
      ctrl.div_mul  = div_stage_ff[1];
      ctrl.div_wr   = div_stage_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remap_x_ff   <= REMAP_POS_X;
         remap_y_ff   <= REMAP_POS_Y;
         remap_z_ff   <= REMAP_POS_Z;
         one_g_ff     <= ONE_G_RESET;
         cnt_ff       <= '0;
         cal_ff       <= 1'b0;
         div_stage_ff <= '0;
      end else begin
         remap_x_ff   <= remap_x_in;
         remap_y_ff   <= remap_y_in;
         remap_z_ff   <= remap_z_in;
         one_g_ff     <= one_g_in;
         cnt_ff       <= cnt_in;
         cal_ff       <= cal_in;
         div_stage_ff <= div_stage_in;
      end
   end

   // one lane per logical axis, the level bias only on x
   asrl_lane #(.CAL_SAMPLE_COUNT(CAL_SAMPLE_COUNT)) u_lane_x (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .logical_val (log_x),
      .load_val    (req_word.load_offset_x),
      .level_bias  (one_g_ff),
      .axis_out    (lane_x)
   );

   asrl_lane #(.CAL_SAMPLE_COUNT(CAL_SAMPLE_COUNT)) u_lane_y (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .logical_val (log_y),
      .load_val    (req_word.load_offset_y),
      .level_bias  ('0),
      .axis_out    (lane_y)
   );

   asrl_lane #(.CAL_SAMPLE_COUNT(CAL_SAMPLE_COUNT)) u_lane_z (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .logical_val (log_z),
      .load_val    (req_word.load_offset_z),
      .level_bias  ('0),
      .axis_out    (lane_z)
   );

   asrl_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .lane_x   (lane_x),
      .lane_y   (lane_y),
      .lane_z   (lane_z),
      .cal_flag (cal_next),
      .cal_done (complete),
      .space_ok (space_ok),
      .rsp_port (rsp_port)
   );

   // checks
   a_stage_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(div_stage_ff))
      else $error("mean pipeline holds more than one calibration");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_accept)
      else $error("word accepted while offsets are being written");

   a_complete_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && complete) |=> div_stage_ff[0])
      else $error("completed calibration did not start the mean pipeline");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CAL_CNT)
      else $error("sample count reached the calibration length");

   a_flag_after_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && complete) |=> cal_ff)
      else $error("calibrated flag not set after completion");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import asrl_pkg::*;

   localparam int CAL_SAMPLES       = 8;
   localparam int RESET_CYCLES      = 12;
   localparam int CFG_SETTLE        = 8;
   localparam int END_SETTLE        = 10;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int REPORT_LIMIT      = 10;

   localparam logic [MODE_W-1:0]    MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]    MODE_SPARE_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX  = 3'd7;
   localparam logic [REMAP_W-1:0]   REMAP_ZERO       = 3'b000;
   localparam logic [REMAP_W-1:0]   REMAP_NONE       = 3'b100;
   localparam logic [RAW_W-1:0]     AXIS_MAX         = 12'h7FF;
   localparam logic [RAW_W-1:0]     AXIS_MIN         = 12'h800;
   localparam logic [RAW_W-1:0]     AXIS_NEG_ONE     = 12'hFFF;

   logic clock;
   logic reset;

   asrl_chan_if #(.payload_type(req_word_type)) req_if ();
   asrl_chan_if #(.payload_type(rsp_word_type)) rsp_if ();
   asrl_chan_if #(.payload_type(csr_word_type)) csr_if ();

   accel_sample_remap_level_cal_unit #(
      .CAL_SAMPLE_COUNT(CAL_SAMPLES)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_if),
      .rsp_port(rsp_if),
      .csr_port(csr_if)
   );

   // clock, 8 ns period
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // settings and calibration state as the block should hold them
   logic [REMAP_W-1:0] remap_x_sel = REMAP_POS_X;
   logic [REMAP_W-1:0] remap_y_sel = REMAP_POS_Y;
   logic [REMAP_W-1:0] remap_z_sel = REMAP_POS_Z;
   logic [ONE_G_W-1:0] one_g_level = ONE_G_RESET;
   logic [AXIS_W-1:0]  level_off_x = '0;
   logic [AXIS_W-1:0]  level_off_y = '0;
   logic [AXIS_W-1:0]  level_off_z = '0;
   logic               cal_flag    = 1'b0;
   int                 axis_sum_x  = 0;
   int                 axis_sum_y  = 0;
   int                 axis_sum_z  = 0;
   logic [CNT_W-1:0]   cal_count   = '0;

   req_word_type req_pending[$];
   rsp_word_type expected_samples[$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic long_stall_req = 1'b0;
   int   stall_left     = 0;
   int   failures       = 0;
   int   idle_cycles    = 0;

   // 12-bit left-aligned axis, sign extended
   function automatic int raw_axis(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi);
      logic signed [RAW_W-1:0] a;
      a = {hi, lo[BYTE_W-1:4]};
      return int'(a);
   endfunction

   // logical axis picked by a signed code, negative inverts, no axis gives zero
   function automatic int remapped_axis(input logic [REMAP_W-1:0] code,
                                        input int px, input int py, input int pz);
      int c;
      int mag;
      int v;
      c = int'($signed(code));
      mag = (c < 0) ? -c : c;
      case (mag)
         1: v = px;
         2: v = py;
         3: v = pz;
         default: v = 0;
      endcase
      return (c < 0) ? -v : v;
   endfunction

   function automatic void clear_cal_sums();
      axis_sum_x = 0;
      axis_sum_y = 0;
      axis_sum_z = 0;
      cal_count = '0;
   endfunction

   // expected result word for one accepted sample, updates the calibration state
   function automatic void predict_sample(input req_word_type w);
      int px;
      int py;
      int pz;
      int mean_x;
      rsp_word_type r;
      px = raw_axis(w.x_low_byte, w.x_high_byte);
      py = raw_axis(w.y_low_byte, w.y_high_byte);
      pz = raw_axis(w.z_low_byte, w.z_high_byte);

      // offset changes that apply before the subtraction
      case (w.mode)
         MODE_CAL_START: begin
            level_off_x = '0;
            level_off_y = '0;
            level_off_z = '0;
            clear_cal_sums();
         end
         MODE_CAL_ABORT: begin
            cal_flag = 1'b0;
            clear_cal_sums();
         end
         MODE_LOAD: begin
            level_off_x = w.load_offset_x;
            level_off_y = w.load_offset_y;
            level_off_z = w.load_offset_z;
            cal_flag = 1'b1;
         end
         default: ;
      endcase

      r.accel_x = 16'(remapped_axis(remap_x_sel, px, py, pz)) - level_off_x;
      r.accel_y = 16'(remapped_axis(remap_y_sel, px, py, pz)) - level_off_y;
      r.accel_z = 16'(remapped_axis(remap_z_sel, px, py, pz)) - level_off_z;
      r.calibration_done = 1'b0;

      // accumulate, and on the last sample store the means truncated toward zero
      if (w.mode == MODE_CAL_SAMPLE) begin
         axis_sum_x += int'($signed(r.accel_x));
         axis_sum_y += int'($signed(r.accel_y));
         axis_sum_z += int'($signed(r.accel_z));
         cal_count += 1'b1;
         if (cal_count >= CAL_SAMPLES) begin
            mean_x = axis_sum_x / CAL_SAMPLES + int'(one_g_level);
            level_off_x = 16'(mean_x);
            level_off_y = 16'(axis_sum_y / CAL_SAMPLES);
            level_off_z = 16'(axis_sum_z / CAL_SAMPLES);
            cal_flag = 1'b1;
            r.calibration_done = 1'b1;
            clear_cal_sums();
         end
      end
      r.is_calibrated = cal_flag;
      expected_samples.push_back(r);
   endfunction

   // compare one result word against the oldest expectation
   function automatic void check_sample(input rsp_word_type got);
      rsp_word_type want;
      string bad;
      if (expected_samples.size() == 0) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("result word with nothing expected: x %0d y %0d z %0d cal %0b done %0b",
                     got.accel_x, got.accel_y, got.accel_z, got.is_calibrated,
                     got.calibration_done);
         return;
      end
      want = expected_samples.pop_front();
      bad = "";
      if (got.accel_x !== want.accel_x) bad = {bad, " accel_x"};
      if (got.accel_y !== want.accel_y) bad = {bad, " accel_y"};
      if (got.accel_z !== want.accel_z) bad = {bad, " accel_z"};
      if (got.is_calibrated !== want.is_calibrated) bad = {bad, " is_calibrated"};
      if (got.calibration_done !== want.calibration_done) bad = {bad, " calibration_done"};
      if (bad != "") begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("mismatch in%s: expected x %0d y %0d z %0d cal %0b done %0b, got x %0d y %0d z %0d cal %0b done %0b",
                     bad, want.accel_x, want.accel_y, want.accel_z, want.is_calibrated,
                     want.calibration_done, got.accel_x, got.accel_y, got.accel_z,
                     got.is_calibrated, got.calibration_done);
      end
   endfunction

   // axis values: small tilt, full-scale corners or anything
   function automatic logic [RAW_W-1:0] random_axis();
      case ($urandom_range(3))
         0: return RAW_W'($urandom_range(127)) - 12'd64;
         1: begin
            case ($urandom_range(3))
               0: return AXIS_MAX;
               1: return AXIS_MIN;
               2: return AXIS_NEG_ONE;
               default: return '0;
            endcase
         end
         default: return RAW_W'($urandom);
      endcase
   endfunction

   function automatic logic [AXIS_W-1:0] random_offset();
      if ($urandom_range(1) != 0) return AXIS_W'($urandom);
      return AXIS_W'($urandom_range(255)) - 16'd128;
   endfunction

   // sample word from 12-bit axes, spare low nibbles and offsets random
   function automatic req_word_type sample_word(input logic [MODE_W-1:0] mode,
                                                input logic [RAW_W-1:0] xv,
                                                input logic [RAW_W-1:0] yv,
                                                input logic [RAW_W-1:0] zv);
      req_word_type w;
      w.mode = mode;
      w.x_high_byte = xv[RAW_W-1:4];
      w.x_low_byte = {xv[3:0], 4'($urandom)};
      w.y_high_byte = yv[RAW_W-1:4];
      w.y_low_byte = {yv[3:0], 4'($urandom)};
      w.z_high_byte = zv[RAW_W-1:4];
      w.z_low_byte = {zv[3:0], 4'($urandom)};
      w.load_offset_x = random_offset();
      w.load_offset_y = random_offset();
      w.load_offset_z = random_offset();
      return w;
   endfunction

   // mostly calibration runs around a fixed attitude, the rest loose words
   function automatic void queue_random_traffic(input int n_words);
      int queued;
      int choice;
      int abort_at;
      logic [RAW_W-1:0] bx;
      logic [RAW_W-1:0] by;
      logic [RAW_W-1:0] bz;
      queued = 0;
      while (queued < n_words) begin
         choice = $urandom_range(99);
         if (choice < 45) begin
            if ($urandom_range(3) != 0) begin
               req_pending.push_back(sample_word(MODE_CAL_START, random_axis(),
                                                 random_axis(), random_axis()));
               queued++;
            end
            bx = random_axis();
            by = random_axis();
            bz = random_axis();
            abort_at = ($urandom_range(5) == 0) ? $urandom_range(CAL_SAMPLES - 1) : CAL_SAMPLES;
            for (int i = 0; i < CAL_SAMPLES; i++) begin
               if (i == abort_at) begin
                  req_pending.push_back(sample_word(MODE_CAL_ABORT, random_axis(),
                                                    random_axis(), random_axis()));
                  queued++;
                  break;
               end
               req_pending.push_back(sample_word(MODE_CAL_SAMPLE,
                                                 bx + RAW_W'($urandom_range(15)) - 12'd8,
                                                 by + RAW_W'($urandom_range(15)) - 12'd8,
                                                 bz + RAW_W'($urandom_range(15)) - 12'd8));
               queued++;
            end
         end else if (choice < 60) begin
            req_pending.push_back(sample_word(MODE_LOAD, random_axis(), random_axis(),
                                              random_axis()));
            queued++;
         end else if (choice < 66) begin
            req_pending.push_back(sample_word(MODE_CAL_ABORT, random_axis(), random_axis(),
                                              random_axis()));
            queued++;
         end else if (choice < 74) begin
            req_pending.push_back(sample_word(MODE_W'($urandom_range(MODE_SPARE_FIRST,
                                                                     MODE_SPARE_LAST)),
                                              random_axis(), random_axis(), random_axis()));
            queued++;
         end else if (choice < 80) begin
            req_pending.push_back(sample_word(MODE_CAL_SAMPLE, random_axis(), random_axis(),
                                              random_axis()));
            queued++;
         end else begin
            req_pending.push_back(sample_word(MODE_READ, random_axis(), random_axis(),
                                              random_axis()));
            queued++;
         end
      end
   endfunction

   // one register write on the control port
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [ONE_G_W-1:0] value);
      csr_word_type c;
      c.index = index;
      c.wdata = value;
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= c;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
      case (index)
         CSR_REMAP_X: remap_x_sel = value[REMAP_W-1:0];
         CSR_REMAP_Y: remap_y_sel = value[REMAP_W-1:0];
         CSR_REMAP_Z: remap_z_sel = value[REMAP_W-1:0];
         CSR_ONE_G:   one_g_level = value;
         default: ;
      endcase
   endtask

   // let the block settle, then write all four registers
   task automatic apply_settings(input logic [REMAP_W-1:0] rx, input logic [REMAP_W-1:0] ry,
                                 input logic [REMAP_W-1:0] rz, input logic [ONE_G_W-1:0] g);
      repeat (CFG_SETTLE) @(posedge clock);
      write_csr(CSR_REMAP_X, {10'($urandom), rx});
      write_csr(CSR_REMAP_Y, {10'($urandom), ry});
      write_csr(CSR_REMAP_Z, {10'($urandom), rz});
      write_csr(CSR_ONE_G, g);
   endtask

   task automatic drain_results();
      while (req_pending.size() != 0 || req_if.valid || expected_samples.size() != 0)
         @(posedge clock);
   endtask

   // sample driver, fed from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) predict_sample(req_if.data);
         if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.data <= req_pending.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result monitor with random and long receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_sample(rsp_if.data);
         if (long_stall_req) begin
            stall_left <= LONG_STALL_CYCLES;
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                   (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // phases of stimulus and settings
   initial begin
      req_word_type w;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // zero sample, full-scale corners and spare modes
      req_pending.push_back(sample_word(MODE_READ, '0, '0, '0));
      req_pending.push_back(sample_word(MODE_READ, AXIS_MAX, AXIS_MIN, AXIS_NEG_ONE));
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
         req_pending.push_back(sample_word(MODE_W'(m), random_axis(), random_axis(),
                                           random_axis()));
      // calibration samples with no start before them
      req_pending.push_back(sample_word(MODE_CAL_SAMPLE, random_axis(), random_axis(),
                                        random_axis()));
      req_pending.push_back(sample_word(MODE_CAL_SAMPLE, random_axis(), random_axis(),
                                        random_axis()));
      // full level run, negative sums that do not divide evenly
      req_pending.push_back(sample_word(MODE_CAL_START, AXIS_MAX, AXIS_MAX, AXIS_MAX));
      for (int i = 0; i < CAL_SAMPLES; i++)
         req_pending.push_back(sample_word(MODE_CAL_SAMPLE, 12'd1024 + RAW_W'(i),
                                           (i < 3) ? AXIS_NEG_ONE : 12'd0, RAW_W'(-i)));
      req_pending.push_back(sample_word(MODE_READ, 12'd1024, '0, '0));
      // abort keeps offsets but drops the flag
      req_pending.push_back(sample_word(MODE_CAL_ABORT, 12'd1024, '0, '0));
      req_pending.push_back(sample_word(MODE_READ, AXIS_MIN, AXIS_MAX, '0));
      // extreme offsets loaded, subtraction wraps
      w = sample_word(MODE_LOAD, AXIS_MAX, AXIS_MIN, AXIS_NEG_ONE);
      w.load_offset_x = 16'h8000;
      w.load_offset_y = 16'h7FFF;
      w.load_offset_z = 16'hFFFF;
      req_pending.push_back(w);
      // run broken off after two samples
      req_pending.push_back(sample_word(MODE_CAL_START, random_axis(), random_axis(),
                                        random_axis()));
      req_pending.push_back(sample_word(MODE_CAL_SAMPLE, AXIS_MIN, AXIS_MIN, AXIS_MIN));
      req_pending.push_back(sample_word(MODE_CAL_SAMPLE, AXIS_MAX, AXIS_MAX, AXIS_MAX));
      req_pending.push_back(sample_word(MODE_CAL_ABORT, random_axis(), random_axis(),
                                        random_axis()));
      queue_random_traffic(160);
      drain_results();

      // sender idle most cycles, inverted axes, no gravity term
      apply_settings(REMAP_NEG_X, REMAP_POS_Z, REMAP_NEG_Y, 13'd0);
      send_idle_pct <= 75;
      queue_random_traffic(90);
      // sender holds back until every result is in
      drain_results();
      queue_random_traffic(90);
      drain_results();

      // receiver stalling most cycles, zero and absent codes, full-scale gravity
      apply_settings(REMAP_ZERO, REMAP_NONE, REMAP_NEG_Z, 13'd4096);
      send_idle_pct <= 0;
      recv_stall_pct <= 75;
      queue_random_traffic(180);
      drain_results();

      // light idling on both sides, one long receiver hold-off to fill the block
      apply_settings(REMAP_POS_Y, REMAP_POS_X, REMAP_POS_Z, 13'($urandom_range(4096)));
      send_idle_pct <= 11;
      recv_stall_pct <= 11;
      long_stall_req <= 1'b1;
      queue_random_traffic(60);
      @(posedge clock);
      long_stall_req <= 1'b0;
      queue_random_traffic(120);
      drain_results();

      // random codes, write to an unmapped index, no idling
      apply_settings(3'($urandom), 3'($urandom), 3'($urandom), 13'($urandom_range(4096)));
      write_csr(CSR_SPARE_INDEX, 13'($urandom));
      send_idle_pct <= 0;
      recv_stall_pct <= 0;
      queue_random_traffic(180);
      drain_results();

      repeat (END_SETTLE) @(posedge clock);
      if (failures == 0 && expected_samples.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
